>>> rtl/core/chf_pkg.sv
// ----------------------------------------------------------------------------
// chf_pkg
// Shared constants, types and command codes for the complex halfband FIR.
// ----------------------------------------------------------------------------
package chf_pkg;

    // Filter geometry
    localparam int TAPS   = 63;
    localparam int CENTER = TAPS / 2;
    localparam int NCOEF  = (TAPS / 2 + 1) / 2 + 1;

    // Number of symmetric pairs that fall inside the window
    function automatic int count_pairs();
        int n;
        n = 0;
        for (int k = 1; k < NCOEF; k++) begin
            if ((2 * k - 1) <= CENTER && (CENTER + 2 * k - 1) < TAPS) begin
                n++;
            end
        end
        return n;
    endfunction

    // One pass per coefficient: centre tap plus every pair
    localparam int NSTEP  = count_pairs() + 1;
    // Slots beyond 31 cannot be addressed by a 5-bit index
    localparam int CDEPTH = (NCOEF > 32) ? 32 : NCOEF;
    localparam int CIW    = $clog2(CDEPTH);
    localparam int AW     = $clog2(TAPS);
    localparam int FW     = $clog2(TAPS + 1);
    localparam int KW     = $clog2(NSTEP);
    // Age (0 = newest) of the centre sample
    localparam int AGE_C  = TAPS - 1 - CENTER;

    // Stream widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    // Command codes carried in tuser
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef logic signed [15:0] t_s16;

    // One complex sample as held in the window memory
    typedef struct packed {
        t_s16 im;
        t_s16 re;
    } t_cplx;

    // Per-step control travelling alongside the read data
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic en_a;
        logic en_b;
    } t_mac_ctrl;

    // Accumulator result back to the sequencer
    typedef struct packed {
        logic        done;
        logic [31:0] acc_re;
        logic [31:0] acc_im;
    } t_mac_res;

endpackage

>>> rtl/core/complex_halfband_fir_filter_top.sv
// ----------------------------------------------------------------------------
// complex_halfband_fir_filter_top
// Complex Q15 halfband FIR with a circular sample window and one shared MAC.
// ----------------------------------------------------------------------------
// Each item carries a command in tuser. A load item writes one Q15
// coefficient (slot 0 is the centre tap, slot k the pair at offset 2k-1)
// and is taken with no result while the block stays idle; slots past the
// last one are dropped. A filter item shifts a complex sample into a
// TAPS-deep window and yields one output item. Filtering makes one
// pre-add/multiply/accumulate pass per coefficient through the shared MAC,
// fed from two copies of the window RAM, then drains the read and MAC
// pipeline registers. tready is low for that whole time. A finished
// result sits in the output register while the next item is accepted; the
// block waits only if a second result is ready before the first is taken.
// All coefficients must be loaded before the first filter item. The window
// reads as zero after reset through a fill count; no clearing pass is run.
// ----------------------------------------------------------------------------
module complex_halfband_fir_filter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: sample_re[15:0], sample_im[31:16], coef_index[36:32],
    //        coef_value[52:37], zero fill [55:53]
    input  logic [chf_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: command
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: out_re[15:0], out_im[31:16]
    output logic [chf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);
    import chf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_HOLD
    } t_state;

    t_state          r_state;
    logic [KW-1:0]   r_k;
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_newest;
    logic [FW-1:0]   r_fill;
    logic            r_last;
    logic            r_out_valid;
    logic [31:0]     r_out_data;
    logic            r_out_last;
    t_mac_ctrl       r_iss;

    logic            w_accept;
    logic            w_filter;
    logic            w_load;
    logic            w_out_free;
    logic [4:0]      w_cidx_in;
    logic            w_coef_we;
    t_cplx           w_wdata;
    t_cplx           w_rd_a;
    t_cplx           w_rd_b;
    logic [AW:0]     w_off;
    logic [AW:0]     w_age_a;
    logic [AW:0]     w_age_b;
    logic [AW-1:0]   w_addr_a;
    logic [AW-1:0]   w_addr_b;
    logic [CIW-1:0]  w_cidx;
    t_s16            w_iss_coef;
    t_mac_ctrl       w_ctrl;
    t_mac_res        w_res;

    // Physical address of the sample of a given age
    function automatic logic [AW-1:0] age_addr(input logic [AW-1:0] newest,
                                              input logic [AW:0] age);
        logic [AW:0] n;
        logic [AW:0] t;
        n = {1'b0, newest};
        if (n >= age) begin
            t = n - age;
        end else begin
            t = n + (AW+1)'(TAPS) - age;
        end
        return t[AW-1:0];
    endfunction

    // Input handshake decode
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_filter      = w_accept && (s_axis_tuser == CMD_FILTER);
    assign w_load        = w_accept && (s_axis_tuser == CMD_LOAD);
    assign w_cidx_in     = s_axis_tdata[36:32];
    assign w_wdata.re    = s_axis_tdata[15:0];
    assign w_wdata.im    = s_axis_tdata[31:16];
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Tap ages for this step: centre + offset (older), centre - offset
    assign w_off    = (r_k == '0) ? '0 : (((AW+1)'(r_k)) << 1) - (AW+1)'(1);
    assign w_age_a  = (AW+1)'(AGE_C) + w_off;
    assign w_age_b  = (AW+1)'(AGE_C) - w_off;
    assign w_addr_a = age_addr(r_newest, w_age_a);
    assign w_addr_b = age_addr(r_newest, w_age_b);

    // Coefficient slot for this step
    assign w_cidx = CIW'(r_k);

    // Step control; samples not yet shifted in read as zero
    always_comb begin
        w_ctrl       = '0;
        w_ctrl.valid = (r_state == S_RUN);
        w_ctrl.first = (r_k == '0);
        w_ctrl.last  = (r_k == KW'(NSTEP - 1));
        w_ctrl.en_a  = w_age_a < (AW+1)'(r_fill);
        w_ctrl.en_b  = (r_k != '0) && (w_age_b < (AW+1)'(r_fill));
    end

    // Align step control with the registered RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss <= '0;
        end else begin
            r_iss <= w_ctrl;
        end
    end

    // Coefficient store; registered read lines up with the window reads
    assign w_coef_we = w_load && (int'(w_cidx_in) < CDEPTH);

    chf_ram #(
        .WIDTH ($bits(t_s16)),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_cidx_in[CIW-1:0]),
        .i_wdata (s_axis_tdata[52:37]),
        .i_raddr (w_cidx),
        .o_rdata (w_iss_coef)
    );

    // Two window copies so both taps of a pair are read in the same cycle
    chf_ram #(
        .WIDTH ($bits(t_cplx)),
        .DEPTH (TAPS)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_filter),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_raddr (w_addr_a),
        .o_rdata (w_rd_a)
    );

    chf_ram #(
        .WIDTH ($bits(t_cplx)),
        .DEPTH (TAPS)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_filter),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_raddr (w_addr_b),
        .o_rdata (w_rd_b)
    );

    chf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_iss),
        .i_a     (w_rd_a),
        .i_b     (w_rd_b),
        .i_coef  (w_iss_coef),
        .o_res   (w_res)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_wp        <= '0;
            r_newest    <= '0;
            r_fill      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_filter) begin
                        r_newest <= r_wp;
                        r_wp     <= (r_wp == AW'(TAPS - 1)) ? '0 : r_wp + AW'(1);
                        if (r_fill != FW'(TAPS)) begin
                            r_fill <= r_fill + FW'(1);
                        end
                        r_last  <= s_axis_tlast;
                        r_k     <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_k <= r_k + KW'(1);
                    if (r_k == KW'(NSTEP - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN, S_HOLD: begin
                    if (r_state == S_HOLD || w_res.done) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= {w_res.acc_im[30:15], w_res.acc_re[30:15]};
                            r_out_last  <= r_last;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Checks
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> (r_state == S_DRAIN))
        else $error("MAC finished outside the drain phase");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= TAPS)
        else $error("window fill count past TAPS");

    a_filter_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_FILTER))
        |=> (r_state == S_RUN) && (r_k == '0))
        else $error("filter item did not start a coefficient pass");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (int'(r_k) < NSTEP))
        else $error("step counter out of range");

endmodule

>>> rtl/core/chf_ram.sv
// ----------------------------------------------------------------------------
// chf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chf_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/core/chf_mac.sv
// ----------------------------------------------------------------------------
// chf_mac
// Shared pre-add, multiply and accumulate unit, one lane each for the real
// and imaginary parts. Three register stages: pre-add, product, accumulate.
// ----------------------------------------------------------------------------
module chf_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  chf_pkg::t_mac_ctrl  i_ctrl,
    input  chf_pkg::t_cplx      i_a,
    input  chf_pkg::t_cplx      i_b,
    input  chf_pkg::t_s16       i_coef,
    output chf_pkg::t_mac_res   o_res
);
    import chf_pkg::*;

    t_mac_ctrl          r_s1_ctrl;
    t_mac_ctrl          r_s2_ctrl;
    logic signed [16:0] r_pre_re;
    logic signed [16:0] r_pre_im;
    t_s16               r_s1_coef;
    logic [31:0]        r_prod_re;
    logic [31:0]        r_prod_im;
    logic [31:0]        r_acc_re;
    logic [31:0]        r_acc_im;
    logic               r_done;

    logic signed [16:0] w_a_re, w_a_im, w_b_re, w_b_im;
    logic signed [32:0] w_prod_re, w_prod_im;

    // Gate samples that lie beyond the filled part of the window
    assign w_a_re = i_ctrl.en_a ? 17'(i_a.re) : '0;
    assign w_a_im = i_ctrl.en_a ? 17'(i_a.im) : '0;
    assign w_b_re = i_ctrl.en_b ? 17'(i_b.re) : '0;
    assign w_b_im = i_ctrl.en_b ? 17'(i_b.im) : '0;

    // 17 x 16 signed products; low 32 bits wrap as the accumulator does
    assign w_prod_re = r_pre_re * r_s1_coef;
    assign w_prod_im = r_pre_im * r_s1_coef;

    // Control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctrl <= '0;
            r_s2_ctrl <= '0;
            r_done    <= 1'b0;
        end else begin
            r_s1_ctrl <= i_ctrl;
            r_s2_ctrl <= r_s1_ctrl;
            r_done    <= r_s2_ctrl.valid && r_s2_ctrl.last;
        end
    end

    // Datapath: pre-add, product, accumulate
    always_ff @(posedge i_clk) begin
        r_pre_re  <= w_a_re + w_b_re;
        r_pre_im  <= w_a_im + w_b_im;
        r_s1_coef <= i_coef;
        r_prod_re <= w_prod_re[31:0];
        r_prod_im <= w_prod_im[31:0];
        if (r_s2_ctrl.valid) begin
            r_acc_re <= r_s2_ctrl.first ? r_prod_re : r_acc_re + r_prod_re;
            r_acc_im <= r_s2_ctrl.first ? r_prod_im : r_acc_im + r_prod_im;
        end
    end

    assign o_res.done   = r_done;
    assign o_res.acc_re = r_acc_re;
    assign o_res.acc_im = r_acc_im;

endmodule

>>> test/chf_filter_checker.sv
// ----------------------------------------------------------------------------
// chf_filter_checker
// Watches both streams of the complex halfband FIR, predicts every output
// item from the accepted input items and compares field by field.
// ----------------------------------------------------------------------------
module chf_filter_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [chf_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic                             i_s_tlast,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [chf_pkg::OUT_TDATA_W-1:0]  i_m_tdata,
    input  logic                             i_m_tlast,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    output int                               o_pending,
    output int                               o_errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import chf_pkg::*;

    // One filtered output item
    typedef struct packed {
        t_s16 re;
        t_s16 im;
        logic last;
    } t_filt_out;

    t_cplx      window [TAPS];
    t_s16       coefs  [NCOEF];
    t_filt_out  filtered_q [$];
    int         error_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Shift a sample into the window and work out the filtered item
    function automatic t_filt_out shift_and_filter(input t_cplx smp, input logic last);
        logic signed [31:0] acc_re;
        logic signed [31:0] acc_im;
        logic signed [16:0] pair_re;
        logic signed [16:0] pair_im;
        int                 off;
        t_filt_out          res;
        for (int i = 0; i < TAPS - 1; i++) begin
            window[i] = window[i + 1];
        end
        window[TAPS - 1] = smp;
        acc_re = coefs[0] * window[CENTER].re;
        acc_im = coefs[0] * window[CENTER].im;
        for (int k = 1; k < NCOEF; k++) begin
            off = 2 * k - 1;
            if (off > CENTER || CENTER + off >= TAPS) begin
                break;
            end
            // symmetric pair pre-added at 17 bits
            pair_re = window[CENTER - off].re + window[CENTER + off].re;
            pair_im = window[CENTER - off].im + window[CENTER + off].im;
            acc_re += coefs[k] * pair_re;
            acc_im += coefs[k] * pair_im;
        end
        res.re   = acc_re[30:15];
        res.im   = acc_im[30:15];
        res.last = last;
        return res;
    endfunction

    // Input side: update state; output side: compare with oldest prediction
    always @(posedge i_clk) begin
        t_filt_out want;
        t_cplx     smp;
        logic [4:0] idx;
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                window[i] = '0;
            end
            filtered_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_LOAD) begin
                    idx = i_s_tdata[36:32];
                    if (idx < NCOEF) begin
                        coefs[idx] = i_s_tdata[52:37];
                    end
                end else begin
                    smp.re = i_s_tdata[15:0];
                    smp.im = i_s_tdata[31:16];
                    filtered_q.push_back(shift_and_filter(smp, i_s_tlast));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch("output item with nothing expected", i_m_tdata, 0);
                end else begin
                    want = filtered_q.pop_front();
                    if (t_s16'(i_m_tdata[15:0]) != want.re)
                        report_mismatch("out_re", t_s16'(i_m_tdata[15:0]), want.re);
                    if (t_s16'(i_m_tdata[31:16]) != want.im)
                        report_mismatch("out_im", t_s16'(i_m_tdata[31:16]), want.im);
                    if (i_m_tlast !== want.last)
                        report_mismatch("out_block_last", i_m_tlast, want.last);
                end
            end
        end
        o_pending <= filtered_q.size();
        o_errors  <= error_count;
    end

endmodule

>>> test/tb_complex_halfband_fir_filter_top.sv
// ----------------------------------------------------------------------------
// tb_complex_halfband_fir_filter_top
// Stimulus and verdict for the complex halfband FIR top level.
// ----------------------------------------------------------------------------
// Loads every coefficient slot, runs a short directed set of extreme samples
// and coefficients, then random mixes of filter and load items over four
// flow-control phases. A separate checker predicts and compares each output.
// ----------------------------------------------------------------------------
module tb_complex_halfband_fir_filter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import chf_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int ITEMS_PHASE  = 220;
    localparam int SETTLE_CYCLES = 40;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    s_axis_tuser = CMD_FILTER;
    logic                    s_axis_tlast = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;

    int pending;
    int errors;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    complex_halfband_fir_filter_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    chf_filter_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tlast  (s_axis_tlast),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tlast  (m_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Run guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("complex_halfband_fir_filter_top: mismatch");
            $finish;
        end
    end

    // Random 16-bit value, biased towards the extremes and small values near zero
    function automatic t_s16 rand_s16();
        case ($urandom_range(7))
            0: return (($urandom_range(1) == 1) ? 16'sh7FFF : 16'sh8000);
            1: return t_s16'($urandom_range(3)) - 16'sd2;
            default: return t_s16'($urandom());
        endcase
    endfunction

    // Present one item, with random idle gaps, and wait for it to be taken
    task automatic send_item(input logic cmd, input t_s16 re, input t_s16 im,
                             input logic [4:0] idx, input t_s16 val, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {3'b000, val, idx, im, re};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Sample and tlast fields of a load are don't-care, so randomise them
    task automatic load_coef(input logic [4:0] idx, input t_s16 val);
        send_item(CMD_LOAD, rand_s16(), rand_s16(), idx, val, 1'($urandom_range(1)));
    endtask

    // Coefficient fields of a filter item are don't-care
    task automatic filter_sample(input t_s16 re, input t_s16 im, input logic last);
        send_item(CMD_FILTER, re, im, 5'($urandom_range(31)), rand_s16(), last);
    endtask

    // Hold off the sender until every expected output item has arrived
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [4:0] idx;
        // Reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every slot at the negative extreme, out-of-range slots
        for (int k = 0; k < NCOEF; k++) begin
            load_coef(5'(k), 16'sh8000);
        end
        load_coef(5'(NCOEF), 16'sh7FFF);
        load_coef(5'd31, 16'sh7FFF);
        filter_sample(16'sh8000, 16'sh8000, 1'b1);
        filter_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        filter_sample(16'sh8000, 16'sh7FFF, 1'b1);
        filter_sample(16'sh7FFF, 16'sh8000, 1'b0);
        filter_sample(16'sh0000, 16'shFFFF, 1'b1);
        drain_outputs();

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            // fresh coefficient set; first phase at the positive extreme
            for (int k = 0; k < NCOEF; k++) begin
                load_coef(5'(k), (ph == 0) ? 16'sh7FFF : rand_s16());
            end
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                if (n == ITEMS_PHASE / 2) begin
                    drain_outputs();
                end
                if ($urandom_range(99) < 12) begin
                    idx = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                   : 5'($urandom_range(NCOEF - 1));
                    load_coef(idx, rand_s16());
                end else begin
                    filter_sample(rand_s16(), rand_s16(), 1'($urandom_range(1)));
                end
            end
            drain_outputs();
        end

        // Settle, then verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("complex_halfband_fir_filter_top: match");
        end else begin
            $display("complex_halfband_fir_filter_top: mismatch");
        end
        $finish;
    end

endmodule
